[src/ffa_pkg.sv]
// Shared constants and types for the first-fit free-range allocator.
// Depends on nothing; the allocator top level refers to it by scoped names.
`default_nettype none

package ffa_pkg;

  // Table geometry.
  localparam int unsigned MAX_FREE_RANGES = 64;
  localparam int unsigned ADDR_W          = $clog2(MAX_FREE_RANGES);
  localparam int unsigned CNT_W           = $clog2(MAX_FREE_RANGES + 1);

  // Field widths.
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned STATUS_W = 2;

  // Heap size loaded at reset.
  localparam logic [SLOT_W-1:0] HEAP_SIZE_AT_RESET = SLOT_W'(2048);

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

  // One table entry as stored in the range memory.
  typedef struct packed {
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] length;
  } range_t;

endpackage

`default_nettype wire

[src/first_fit_free_list_allocator.sv]
// First-fit free-range allocator without coalescing (top level).
// Depends on ffa_pkg for table geometry, status codes and the entry type.
`default_nettype none

//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+------------------------------
//  in       | input     | in_valid_i / in_ready_o    | func_i, slot_count_i, free_base_i
//  out      | output    | out_valid_o / out_ready_i  | status_o, alloc_base_o
//  cfg      | input     | cfg_we_i (no wait)         | cfg_wdata_i (heap_slot_count)
//
// A free appends the range, then loads the output register. An allocate scans the table,
// reading one entry a cycle up to the first fit; later entries are copied down one place a
// cycle, then the remainder is appended and the output register loaded; a miss goes to the
// output register once the scan ends. A result waits in the output register while the next
// transaction runs; a second one holds the block until the first is taken. Reset or a heap
// size write leaves one entry covering the heap, entry zero coming from registers until it
// is first written, so no clearing pass runs.

module first_fit_free_list_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              cfg_we_i,
  input  wire logic [ffa_pkg::SLOT_W-1:0]        cfg_wdata_i,

  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              func_i,
  input  wire logic [ffa_pkg::SLOT_W-1:0]        slot_count_i,
  input  wire logic [ffa_pkg::SLOT_W-1:0]        free_base_i,

  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ffa_pkg::STATUS_W-1:0]           status_o,
  output logic [ffa_pkg::SLOT_W-1:0]             alloc_base_o
);

  localparam int unsigned AW = ffa_pkg::ADDR_W;
  localparam int unsigned CW = ffa_pkg::CNT_W;
  localparam int unsigned SW = ffa_pkg::SLOT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(ffa_pkg::MAX_FREE_RANGES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [SW-1:0] heap_q;
  logic [CW-1:0] cnt_q, cnt_d;
  // While set, entry zero of the table is (0, heap size) regardless of memory contents.
  logic          zero_ovr_q;

  logic [SW-1:0] req_count_q, req_count_d;
  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [AW-1:0] sh_idx_q, sh_idx_d;
  logic [SW-1:0] hit_base_q, hit_base_d;
  logic [SW-1:0] hit_len_q, hit_len_d;

  logic [ffa_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [SW-1:0]                res_base_q, res_base_d;

  logic                          out_valid_q;
  logic [ffa_pkg::STATUS_W-1:0] out_status_q;
  logic [SW-1:0]                out_base_q;
  logic                          out_load;

  // Range memory: one write port and one registered read port.
  ffa_pkg::range_t mem_q [ffa_pkg::MAX_FREE_RANGES];
  ffa_pkg::range_t rd_raw_q;
  logic            rd_zero_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  ffa_pkg::range_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_raw_q <= mem_q[mem_raddr];
    end
  end

  // Read data as the table sees it, with the entry-zero override applied.
  logic [SW-1:0] rd_base, rd_len;
  assign rd_base = rd_zero_q ? '0 : rd_raw_q.base;
  assign rd_len  = rd_zero_q ? heap_q : rd_raw_q.length;

  logic [CW-1:0] scan_next, sh_next2;
  assign scan_next = {1'b0, scan_idx_q} + CW'(1);
  assign sh_next2  = {1'b0, sh_idx_q} + CW'(2);

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    req_count_d  = req_count_q;
    scan_idx_d   = scan_idx_q;
    sh_idx_d     = sh_idx_q;
    hit_base_d   = hit_base_q;
    hit_len_d    = hit_len_q;
    res_status_d = res_status_q;
    res_base_d   = res_base_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_count_d = slot_count_i;
          res_base_d  = '0;
          if (func_i == ffa_pkg::FUNC_FREE) begin
            // A free appends the range in this cycle when there is room.
            if (cnt_q < MAX_CNT) begin
              mem_we       = 1'b1;
              mem_waddr    = cnt_q[AW-1:0];
              mem_wdata    = '{base: free_base_i, length: slot_count_i};
              cnt_d        = cnt_q + CW'(1);
              res_status_d = ffa_pkg::STATUS_OK;
            end else begin
              res_status_d = ffa_pkg::STATUS_TABLE_FULL;
            end
            state_d = S_RESULT;
          end else if (cnt_q == '0) begin
            res_status_d = ffa_pkg::STATUS_NO_FIT;
            state_d      = S_RESULT;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = '0;
            scan_idx_d = '0;
            state_d    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read data belongs to scan_idx_q; the next entry is fetched in the same cycle.
        if (rd_len >= req_count_q) begin
          hit_base_d = rd_base;
          hit_len_d  = rd_len;
          sh_idx_d   = scan_idx_q;
          if (scan_next < cnt_q) begin
            mem_re    = 1'b1;
            mem_raddr = scan_next[AW-1:0];
            state_d   = S_SHIFT;
          end else begin
            state_d = S_APPEND;
          end
        end else if (scan_next < cnt_q) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_next[AW-1:0];
          scan_idx_d = scan_next[AW-1:0];
        end else begin
          res_status_d = ffa_pkg::STATUS_NO_FIT;
          state_d      = S_RESULT;
        end
      end

      S_SHIFT: begin
        // Entry sh_idx_q + 1 has arrived; it moves down one place.
        mem_we    = 1'b1;
        mem_waddr = sh_idx_q;
        mem_wdata = '{base: rd_base, length: rd_len};
        if (sh_next2 < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = sh_next2[AW-1:0];
          sh_idx_d  = sh_idx_q + AW'(1);
        end else begin
          state_d = S_APPEND;
        end
      end

      S_APPEND: begin
        // The used entry is gone; a nonzero remainder goes to the end of the table.
        res_status_d = ffa_pkg::STATUS_OK;
        res_base_d   = hit_base_q;
        if (hit_len_q > req_count_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_q - CW'(1));
          mem_wdata = '{base: hit_base_q + req_count_q, length: hit_len_q - req_count_q};
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
        state_d = S_RESULT;
      end

      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_q      <= ffa_pkg::HEAP_SIZE_AT_RESET;
      cnt_q       <= CW'(1);
      zero_ovr_q  <= 1'b1;
      rd_zero_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_re) begin
        rd_zero_q <= zero_ovr_q && (mem_raddr == '0);
      end
      // A heap size write must arrive only while idle; the block does not enforce it, and the write simply wins.
      if (cfg_we_i) begin
        heap_q     <= cfg_wdata_i;
        cnt_q      <= CW'(1);
        zero_ovr_q <= 1'b1;
      end else begin
        cnt_q <= cnt_d;
        if (mem_we && (mem_waddr == '0)) begin
          zero_ovr_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_count_q  <= req_count_d;
    scan_idx_q   <= scan_idx_d;
    sh_idx_q     <= sh_idx_d;
    hit_base_q   <= hit_base_d;
    hit_len_q    <= hit_len_d;
    res_status_q <= res_status_d;
    res_base_q   <= res_base_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_base_q   <= res_base_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign alloc_base_o = out_base_q;

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for the first-fit free-range allocator: directed and random transactions,
// checked against a model of the free-range table kept inside the bench.
// Depends on ffa_pkg and the first_fit_free_list_allocator top level.

module tb;
  import ffa_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 4;
  // No transaction for this many cycles means the block is stuck. The slowest
  // legal gap is the long receiver hold-off plus one full allocate scan.
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 200;

  localparam int unsigned NUM_PHASES        = 8;
  localparam int unsigned PHASE_ITEMS       = 210;
  localparam int unsigned HOLD_PHASE        = 3;
  localparam int unsigned RANDOM_SIZE_PHASE = 5;

  typedef struct {
    logic              func;
    logic [SLOT_W-1:0] count;
    logic [SLOT_W-1:0] base;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   base;
  } reply_t;

  typedef enum {RX_FREE_RUN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [SLOT_W-1:0]   cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                func_i       = FUNC_ALLOC;
  logic [SLOT_W-1:0]   slot_count_i = '0;
  logic [SLOT_W-1:0]   free_base_i  = '0;
  logic                out_ready_i  = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   alloc_base_o;

  first_fit_free_list_allocator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .slot_count_i (slot_count_i),
    .free_base_i  (free_base_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .alloc_base_o (alloc_base_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Our own copy of the free-range table. Only entries below range_count are
  // ever read, so stale entries above it never matter.
  logic [SLOT_W-1:0] range_start [MAX_FREE_RANGES];
  logic [SLOT_W-1:0] range_size  [MAX_FREE_RANGES];
  int unsigned       range_count;

  request_t    pending_q[$];   // transactions waiting to be offered
  reply_t      reply_q[$];     // results expected, oldest first
  int unsigned requests_queued = 0;
  int unsigned requests_taken  = 0;
  int unsigned error_count     = 0;
  int unsigned hold_requests   = 0;

  function automatic void reload_table(logic [SLOT_W-1:0] heap);
    range_start[0] = '0;
    range_size[0]  = heap;
    range_count    = 1;
  endfunction

  // First-fit allocate or plain append on free, exactly as the block does it.
  function automatic reply_t serve_request(request_t rq);
    reply_t            rp;
    int                hit;
    logic [SLOT_W-1:0] hit_base;
    logic [SLOT_W-1:0] hit_len;
    rp.status = STATUS_NO_FIT;
    rp.base   = '0;
    hit       = -1;
    if (rq.func == FUNC_ALLOC) begin
      for (int i = 0; i < range_count; i++) begin
        if (hit < 0 && range_size[i] >= rq.count) hit = i;
      end
      if (hit >= 0) begin
        hit_base  = range_start[hit];
        hit_len   = range_size[hit];
        rp.status = STATUS_OK;
        rp.base   = hit_base;
        // Close the hole, keeping the order of the later entries.
        for (int j = hit; j + 1 < range_count; j++) begin
          range_start[j] = range_start[j + 1];
          range_size[j]  = range_size[j + 1];
        end
        range_count--;
        // The leftover goes to the end; its base wraps at 16 bits.
        if (hit_len > rq.count) begin
          range_start[range_count] = hit_base + rq.count;
          range_size[range_count]  = hit_len - rq.count;
          range_count++;
        end
      end
    end else if (range_count < MAX_FREE_RANGES) begin
      range_start[range_count] = rq.base;
      range_size[range_count]  = rq.count;
      range_count++;
      rp.status = STATUS_OK;
    end else begin
      rp.status = STATUS_TABLE_FULL;
    end
    return rp;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Sender: bursts of random length separated by random gaps. An offered
  // transaction keeps valid and payload steady until the block accepts it.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    request_t next;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        next = pending_q.pop_front();
        in_valid_i   <= 1'b1;
        func_i       <= next.func;
        slot_count_i <= next.count;
        free_base_i  <= next.base;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          // A third of the bursts run straight into the next one.
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern that changes mode at random intervals. When the
  // stimulus asks for a hold-off, ready stays low long enough for the block
  // to fill up and push back on its input.
  rx_mode_e    rx_mode   = RX_FREE_RUN;
  int unsigned rx_left   = 0;
  bit [15:0]   rx_tick   = '0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE_RUN: out_ready_i <= 1'b1;
        RX_COIN:     out_ready_i <= 1'($urandom_range(1));
        RX_SPARSE:   out_ready_i <= ($urandom_range(3) == 0);
        default:     out_ready_i <= rx_tick[2];
      endcase
    end
  end

  // Predictor and checker. Results are compared before the transaction
  // accepted at the same edge is predicted, since a result can never belong
  // to a transaction that is only now being taken.
  always @(posedge clk_i) begin
    reply_t   want;
    request_t seen;
    if (!rst_ni) begin
      reload_table(HEAP_SIZE_AT_RESET);
    end else begin
      if (cfg_we_i) reload_table(cfg_wdata_i);
      if (out_valid_o && out_ready_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with nothing expected, alloc_base", alloc_base_o, 0);
        end else begin
          want = reply_q.pop_front();
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (alloc_base_o !== want.base) report_mismatch("alloc_base", alloc_base_o, want.base);
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen.func  = func_i;
        seen.count = slot_count_i;
        seen.base  = free_base_i;
        reply_q.push_back(serve_request(seen));
        requests_taken++;
      end
    end
  end

  // Watchdog: any cycle without a transaction on either channel counts.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic queue_request(logic func, int unsigned count, int unsigned base);
    request_t rq;
    rq.func  = func;
    rq.count = SLOT_W'(count);
    rq.base  = SLOT_W'(base);
    pending_q.push_back(rq);
    requests_queued++;
  endtask

  // Random transaction: mostly counts that are small next to the heap, so
  // that allocations succeed and split ranges, with zero, the full heap and
  // full-width values mixed in. Free bases mostly land inside the heap.
  function automatic request_t make_request(int unsigned free_pct, int unsigned heap);
    request_t rq;
    rq.func = ($urandom_range(99) < free_pct) ? FUNC_FREE : FUNC_ALLOC;
    case ($urandom_range(9))
      0:       rq.count = '0;
      1:       rq.count = SLOT_W'($urandom());
      2:       rq.count = SLOT_W'(heap);
      default: rq.count = SLOT_W'($urandom_range(1, heap / 8 + 1));
    endcase
    rq.base = ($urandom_range(7) == 0) ? SLOT_W'($urandom()) : SLOT_W'($urandom_range(0, heap));
    return rq;
  endfunction

  // The block is idle once every queued transaction has been taken and
  // every expected result has come back.
  task automatic wait_idle();
    while (requests_taken != requests_queued || reply_q.size() != 0) @(posedge clk_i);
  endtask

  int unsigned phase_heap [NUM_PHASES] = '{1, 0, 65535, 2048, 37, 0, 700, 65535};
  int unsigned phase_free [NUM_PHASES] = '{50, 40, 45, 85, 60, 30, 70, 20};

  initial begin
    int unsigned heap;
    request_t    rq;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset heap of 2048 slots.
    queue_request(FUNC_ALLOC, 0, 0);            // zero-length: whole range moves to the end
    queue_request(FUNC_ALLOC, 100, 0);          // split, remainder appended
    queue_request(FUNC_ALLOC, 65535, 0);        // nothing that large
    queue_request(FUNC_FREE, 65535, 65535);     // out-of-heap free is taken as given
    queue_request(FUNC_ALLOC, 65535, 0);        // exact fit on the second entry
    queue_request(FUNC_ALLOC, 1948, 0);         // exact fit empties the table
    queue_request(FUNC_ALLOC, 0, 0);            // empty table
    queue_request(FUNC_FREE, 10, 16'hFFFF);
    queue_request(FUNC_ALLOC, 3, 0);            // remainder base wraps around
    queue_request(FUNC_FREE, 0, 5);             // zero-length free
    queue_request(FUNC_ALLOC, 0, 0);
    queue_request(FUNC_FREE, 16'hAAAA, 16'h5555);
    queue_request(FUNC_FREE, 16'h5555, 16'hAAAA);
    queue_request(FUNC_ALLOC, 16'hAAAA, 16'hFFFF);
    queue_request(FUNC_ALLOC, 1, 16'h5555);
    queue_request(FUNC_FREE, 0, 0);
    queue_request(FUNC_FREE, 16'hFFFF, 0);      // overlaps ranges already free

    // Random phases, each on a fresh table loaded with that phase's heap size. The
    // mix of frees and allocates shifts from phase to phase so that the table
    // both drains empty and runs full.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      heap = (p == RANDOM_SIZE_PHASE) ? $urandom_range(2, 65534) : phase_heap[p];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= SLOT_W'(heap);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      if (p == HOLD_PHASE) hold_requests++;
      repeat (PHASE_ITEMS) begin
        rq = make_request(phase_free[p], heap);
        queue_request(rq.func, rq.count, rq.base);
      end
    end

    wait_idle();
    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
